// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MM3_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mm3 assertion failed");
`define MM3_ASSERT_NEVER(label, clk, rst_n, cond) \
	`MM3_ASSERT(label, clk, rst_n, !(cond))
`else
`define MM3_ASSERT(label, clk, rst_n, prop)
`define MM3_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- hdl/mm3_pkg.sv -----
package mm3_pkg;

	localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2  = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
	localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

	// Queue between front and back; depth must be a power of two.
	localparam int QDepth = 4;
	localparam int QAW    = $clog2(QDepth);
	localparam int QCW    = $clog2(QDepth + 1);

	typedef struct packed {
		logic       full;
		logic       last;
		logic [2:0] nbytes;
	} mm3_meta_t;

	typedef struct packed {
		logic [31:0] k;
		mm3_meta_t   meta;
	} mm3_item_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] tail_mask(input logic [2:0] cnt);
		logic [31:0] m;
		case (cnt)
			3'd1: m = 32'h0000_00ff;
			3'd2: m = 32'h0000_ffff;
			3'd3: m = 32'h00ff_ffff;
			default: m = 32'h0000_0000;
		endcase
		return m;
	endfunction

endpackage

// ----- hdl/mm3_front.sv -----
module mm3_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         data_word,
	input  logic [2:0]          byte_count,
	input  logic                last_word,
	output logic                item_valid,
	output mm3_pkg::mm3_item_t  item,
	input  logic                item_ready
);
	import mm3_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic [31:0] k_s1, k_s2, k_s3;
	mm3_meta_t   meta_s1, meta_s2, meta_s3;
	logic        adv1, adv2, adv3;
	logic        full_in;
	mm3_meta_t   meta_in;

	assign adv3 = !v_s3 || item_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	// Anything but a short last word counts as four full bytes.
	assign full_in = !last_word || (byte_count >= 3'd4);
	always_comb begin
		meta_in.full   = full_in;
		meta_in.last   = last_word;
		meta_in.nbytes = full_in ? 3'd4 : byte_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			k_s1    <= full_in ? data_word : (data_word & tail_mask(byte_count));
			meta_s1 <= meta_in;
		end
		if (adv2 && v_s1) begin
			k_s2    <= k_s1 * MIX_C1;
			meta_s2 <= meta_s1;
		end
		if (adv3 && v_s2) begin
			k_s3    <= rotl(k_s2, 15) * MIX_C2;
			meta_s3 <= meta_s2;
		end
	end

	assign item_valid = v_s3;
	assign item.k     = k_s3;
	assign item.meta  = meta_s3;

endmodule

// ----- hdl/mm3_fifo.sv -----
`include "assert_macros.svh"

module mm3_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  mm3_pkg::mm3_item_t  push_item,
	output logic                pop_valid,
	input  logic                pop_ready,
	output mm3_pkg::mm3_item_t  pop_item
);
	import mm3_pkg::*;

	mm3_item_t        mem_q [QDepth];
	logic [QAW-1:0]   wr_q, rd_q;
	logic [QCW-1:0]   cnt_q;
	logic             push, pop;

	assign push_ready = (cnt_q != QCW'(QDepth));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QAW'(1);
			if (pop) rd_q <= rd_q + QAW'(1);
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	`MM3_ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > QCW'(QDepth))
	`MM3_ASSERT_NEVER(a_ptr_match, clk, arst_n, QAW'(wr_q - rd_q) != cnt_q[QAW-1:0])
	`MM3_ASSERT(a_cnt_up, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + QCW'(1)))
	`MM3_ASSERT(a_cnt_down, clk, arst_n, (pop && !push) |=> (cnt_q == $past(cnt_q) - QCW'(1)))

endmodule

// ----- hdl/mm3_back.sv -----
`include "assert_macros.svh"

module mm3_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         seed_value,
	input  logic                item_valid,
	output logic                item_ready,
	input  mm3_pkg::mm3_item_t  item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         hash_value
);
	import mm3_pkg::*;

	logic [31:0] acc_q, total_q;
	logic        in_msg_q;
	logic [31:0] h_base, hx, hr, h_new, total_new, f;
	logic        pop;

	logic        v_s1, v_s2, v_s3, out_valid_q;
	logic [31:0] x_s1, x_s2, x_s3, hash_q;
	logic        rdy_s1, rdy_s2, rdy_s3, rdy_o;

	assign rdy_o  = !out_valid_q || out_ready;
	assign rdy_s3 = !v_s3 || rdy_o;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign item_ready = rdy_s1;
	assign pop        = item_valid && rdy_s1;

	// A new message starts from the seed; otherwise continue the running hash.
	assign h_base    = in_msg_q ? acc_q : seed_value;
	assign hx        = h_base ^ item.k;
	assign hr        = rotl(hx, 13);
	assign h_new     = item.meta.full ? ((hr << 2) + hr + MIX_ADD) : hx;
	assign total_new = total_q + {29'd0, item.meta.nbytes};
	assign f         = h_new ^ total_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			total_q  <= '0;
		end else if (pop) begin
			if (item.meta.last) begin
				in_msg_q <= 1'b0;
				total_q  <= '0;
			end else begin
				in_msg_q <= 1'b1;
				total_q  <= total_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !item.meta.last) acc_q <= h_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pop && item.meta.last;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_o) out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.meta.last) x_s1 <= f ^ (f >> 16);
		if (rdy_s2 && v_s1) x_s2 <= x_s1 * FIN_M1;
		if (rdy_s3 && v_s2) x_s3 <= (x_s2 ^ (x_s2 >> 13)) * FIN_M2;
		if (rdy_o && v_s3) hash_q <= x_s3 ^ (x_s3 >> 16);
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	`MM3_ASSERT(a_last_clears, clk, arst_n, (pop && item.meta.last) |=> (!in_msg_q && total_q == '0))
	`MM3_ASSERT(a_body_opens, clk, arst_n, (pop && !item.meta.last) |=> in_msg_q)
	`MM3_ASSERT(a_fin_hold, clk, arst_n, (v_s1 && !rdy_s2) |=> (v_s1 && $stable(x_s1)))

endmodule

// ----- hdl/murmur3_32_hash.sv -----
// MurmurHash3 x86_32 over a stream of little-endian 32-bit words.
// Throughput: one word per cycle unless back-pressure stalls; the accumulator keeps pace.
// The last word runs through the word-scramble registers s1, s2 and s3, then the queue, and
// then the finalization registers x_s1, x_s2, x_s3 and hash_q before the hash is valid.
// Reset clears all pipelines, the queue and the message state; the seed resets to zero.
module murmur3_32_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] seed,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value
);
	import mm3_pkg::*;

	logic [31:0] seed_q;
	logic        f_valid, f_ready, b_valid, b_ready;
	mm3_item_t   f_item, b_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid) begin
			seed_q <= seed;
		end
	end

	mm3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	mm3_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	mm3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_value (seed_q),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.item       (b_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mm3_pkg::*;

	localparam int DRAIN_PAD      = 20;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_WORDS    = 250;

	typedef struct {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        last;
	} word_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_seed = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] data_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] hash_value;

	word_req_t   pending_words[$];
	logic [31:0] hash_expect_q[$];
	word_req_t   drive_req;

	// Mirror of the block's message state.
	logic [31:0] pred_seed = '0;
	logic [31:0] pred_acc = '0;
	logic [31:0] pred_len = '0;
	logic        pred_mid_msg = 1'b0;

	int words_queued = 0;
	int words_accepted = 0;
	int messages_done = 0;
	int hashes_checked = 0;
	int mismatches = 0;
	int seeds_written = 0;
	int idle_cycles = 0;
	int holds_requested = 0;
	int holds_granted = 0;
	int hold_left = 0;
	logic quiet = 1'b0;

	murmur3_32_hash dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seed       (cfg_seed),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] scramble_word(input logic [31:0] k);
		logic [31:0] t;
		t = k * MIX_C1;
		t = rol32(t, 15);
		return t * MIX_C2;
	endfunction

	function automatic logic [31:0] avalanche(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 16);
		t = t * FIN_M1;
		t = t ^ (t >> 13);
		t = t * FIN_M2;
		return t ^ (t >> 16);
	endfunction

	// Absorbs one accepted word and queues the hash when it closes a message.
	function automatic void absorb_word(input logic [31:0] w, input logic [2:0] cnt,
			input logic lst);
		logic [31:0] h;
		logic [31:0] mask;
		h = pred_mid_msg ? pred_acc : pred_seed;
		if (!lst || cnt >= 3'd4) begin
			h = h ^ scramble_word(w);
			h = rol32(h, 13);
			h = h * 32'd5 + MIX_ADD;
			pred_len = pred_len + 32'd4;
		end else if (cnt != 3'd0) begin
			mask = 32'hffff_ffff >> (8 * (4 - int'(cnt)));
			h = h ^ scramble_word(w & mask);
			pred_len = pred_len + 32'(cnt);
		end
		if (!lst) begin
			pred_acc = h;
			pred_mid_msg = 1'b1;
		end else begin
			hash_expect_q.push_back(avalanche(h ^ pred_len));
			pred_acc = pred_seed;
			pred_len = '0;
			pred_mid_msg = 1'b0;
			messages_done++;
		end
	endfunction

	function automatic void add_word(input logic [31:0] w, input logic [2:0] cnt,
			input logic lst);
		word_req_t r;
		r.data = w;
		r.nbytes = cnt;
		r.last = lst;
		pending_words.push_back(r);
		words_queued++;
	endfunction

	function automatic logic [31:0] random_data();
		case ($urandom_range(15))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Mostly short messages, now and then a long one; odd byte counts on
	// body words and saturating counts on the last word are mixed in.
	function automatic void add_random_message();
		int body_len;
		logic [2:0] cnt;
		body_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
		for (int i = 0; i < body_len; i++) begin
			cnt = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'd4;
			add_word(random_data(), cnt, 1'b0);
		end
		add_word(random_data(), 3'($urandom_range(7)), 1'b1);
	endfunction

	task automatic wait_drained();
		while (words_accepted != words_queued || hash_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_seed <= v;
		do @(posedge clk); while (!cfg_ready);
		pred_seed = v;
		if (!pred_mid_msg)
			pred_acc = v;
		seeds_written++;
		cfg_valid <= 1'b0;
	endtask

	// Sender: one request per handshake, random gaps unless quiet.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_word(data_word, byte_count, last_word);
				words_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && (quiet || $urandom_range(99) >= 9)) begin
					drive_req = pending_words.pop_front();
					in_valid <= 1'b1;
					data_word <= drive_req.data;
					byte_count <= drive_req.nbytes;
					last_word <= drive_req.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each hash and applies random or long back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (hash_expect_q.size() == 0) begin
					$display("%0t: unexpected hash 0x%08h, none expected", $time, hash_value);
					mismatches++;
				end else begin
					if (hash_value !== hash_expect_q[0]) begin
						$display("%0t: hash mismatch, expected 0x%08h, actual 0x%08h",
							$time, hash_expect_q[0], hash_value);
						mismatches++;
					end
					void'(hash_expect_q.pop_front());
					hashes_checked++;
				end
			end
			if (holds_granted != holds_requested) begin
				holds_granted++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || ($urandom_range(99) >= 9);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Timeout after %0d cycles without a request", WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [31:0] phase_seeds[5];
		int target;
		logic paused;

		phase_seeds[0] = $urandom;
		phase_seeds[1] = 32'h0000_0000;
		phase_seeds[2] = 32'hffff_ffff;
		phase_seeds[3] = $urandom;
		phase_seeds[4] = $urandom;
		paused = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Seed left at its reset value: empty message, full words, short
		// tails with junk above the count, saturated counts, body words
		// whose count is ignored, and a zero-byte closing word.
		add_word($urandom, 3'd0, 1'b1);
		add_word(32'hffff_ffff, 3'd4, 1'b1);
		add_word(32'h0000_0000, 3'd4, 1'b1);
		add_word(32'hdead_be61, 3'd1, 1'b1);
		add_word(32'ha5a5_6261, 3'd2, 1'b1);
		add_word(32'hff63_6261, 3'd3, 1'b1);
		add_word(32'h6c6c_6548, 3'd5, 1'b1);
		add_word(32'h8000_0001, 3'd6, 1'b1);
		add_word(32'h7fff_fffe, 3'd7, 1'b1);
		add_word(32'h1234_5678, 3'd4, 1'b0);
		add_word(32'hffff_ffff, 3'd2, 1'b0);
		add_word(32'h0000_0000, 3'd0, 1'b0);
		add_word(32'h0f0f_f0f0, 3'd7, 1'b0);
		add_word(32'hcafe_f00d, 3'd3, 1'b1);
		add_word(32'h5555_aaaa, 3'd4, 1'b0);
		add_word(32'haaaa_5555, 3'd0, 1'b1);
		wait_drained();

		write_seed(32'hffff_ffff);
		add_word($urandom, 3'd0, 1'b1);
		add_word(32'haaaa_aaaa, 3'd4, 1'b1);
		add_word(32'h0102_0304, 3'd4, 1'b0);
		wait_drained();

		// A seed change inside a message only applies from the next message.
		write_seed(32'h1234_5678);
		add_word(32'h9abc_def0, 3'd2, 1'b1);
		add_word(32'h0000_00ff, 3'd1, 1'b1);

		for (int p = 0; p < 5; p++) begin
			wait_drained();
			write_seed(phase_seeds[p]);
			quiet = (p == 1);
			if (p == 2)
				holds_requested++;
			target = words_queued + PHASE_WORDS;
			while (words_queued < target) begin
				add_random_message();
				// The sender stops once until every hash has come back.
				if (p == 3 && !paused && words_queued >= target - PHASE_WORDS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
		end
		quiet = 1'b0;
		wait_drained();

		$display("Hashed %0d messages from %0d words; %0d hashes compared, %0d mismatches.",
			messages_done, words_accepted, hashes_checked, mismatches);
		$display("Seed written %0d times: zero, all ones, random, and once inside a message.",
			seeds_written);
		if (mismatches == 0 && hash_expect_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mm3_pkg.sv
hdl/mm3_front.sv
hdl/mm3_fifo.sv
hdl/mm3_back.sv
hdl/murmur3_32_hash.sv
dv/tb_top.sv
